// File: rtl/core/stq_pkg.sv
// Package for the sorted timer queue: sizes, opcodes, status codes and
// sequencer states. Used by sorted_timer_queue; no dependencies.
package stq_pkg;
    localparam int ENTRIES   = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int MAX_POP   = 32;
    localparam int POP_W     = $clog2(MAX_POP + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_PRESENT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,      // walk entries looking for the id
        S_REMOVE,    // shift entries above pos down by one
        S_INSERT,    // walk from the top, shifting up, until the slot is found
        S_TICK,      // compare head expiry with now
        S_POP,       // shift everything down one after a pop
        S_OUT        // result waits in the output register
    } t_state;
endpackage

// File: rtl/core/sorted_timer_queue.sv
// Sorted timer queue: timers kept in ascending expiry in one synchronous
// memory, maintained by a read-modify-write sequencer. Depends on stq_pkg.
//
//  channel | dir | tdata fields (low bit up)          | tuser | tlast
//  s_axis  | in  | opcode, timer_id, expiry, now (82b) | -     | -
//  m_axis  | out | status, expired_valid, expired_id   | -     | last
//
// Each memory step is a read, then a use of its data (a write where entries
// move), over the entries an operation walks; a pop shifts the whole queue.
// One item is worked at a time; the next is taken after its last result has
// been transferred.
// Reset (synchronous, active low) empties the queue; memory contents are
// left as they are. A stalled output holds the sequencer.
module sorted_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // opcode, timer_id, expiry, now, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // status, expired_valid, expired_id, zero fill
    output logic        m_axis_tlast
);
    localparam int IW = stq_pkg::IDX_W;
    localparam int CW = stq_pkg::CNT_W;

    logic [47:0] r_mem [stq_pkg::ENTRIES];   // {id, expiry}
    logic [47:0] r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [47:0]   mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= r_mem[mem_ra];
    end

    stq_pkg::t_state r_state, n_state;
    logic         r_ph, n_ph;          // 0: issue read, 1: use read data
    logic [CW-1:0] r_occ, n_occ;
    logic [CW-1:0] r_pos, n_pos;
    logic [stq_pkg::POP_W-1:0] r_npop, n_npop;
    stq_pkg::t_op r_op, n_op;
    logic [15:0]  r_id, n_id;
    logic [31:0]  r_exp, n_exp;
    logic [31:0]  r_now, n_now;
    logic [1:0]   r_st, n_st;
    logic         r_ov, n_ov;
    logic [15:0]  r_oid, n_oid;
    logic         r_olast, n_olast;
    logic         r_tick_out, n_tick_out; // after output, pop the next due timer

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stq_pkg::S_IDLE;
            r_ph    <= 1'b0;
            r_occ   <= '0;
            r_npop  <= '0;
            r_tick_out <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_occ   <= n_occ;
            r_npop  <= n_npop;
            r_tick_out <= n_tick_out;
        end
        r_pos <= n_pos; r_op <= n_op; r_id <= n_id; r_exp <= n_exp; r_now <= n_now;
        r_st <= n_st; r_ov <= n_ov; r_oid <= n_oid; r_olast <= n_olast;
    end

    always_comb begin
        n_state = r_state; n_ph = r_ph; n_occ = r_occ; n_pos = r_pos;
        n_npop = r_npop; n_op = r_op; n_id = r_id; n_exp = r_exp; n_now = r_now;
        n_st = r_st; n_ov = r_ov; n_oid = r_oid; n_olast = r_olast;
        n_tick_out = r_tick_out;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_re = 1'b0; mem_ra = '0;
        s_axis_tready = (r_state == stq_pkg::S_IDLE);
        case (r_state)
            stq_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op  = stq_pkg::t_op'(s_axis_tdata[1:0]);
                    n_id  = s_axis_tdata[17:2];
                    n_exp = s_axis_tdata[49:18];
                    n_now = s_axis_tdata[81:50];
                    n_pos = '0; n_ph = 1'b0; n_npop = '0;
                    n_st = stq_pkg::ST_OK; n_ov = 1'b0; n_oid = '0; n_olast = 1'b1;
                    n_tick_out = 1'b0;
                    n_state = (stq_pkg::t_op'(s_axis_tdata[1:0]) == stq_pkg::OP_TICK)
                            ? stq_pkg::S_TICK : stq_pkg::S_FIND;
                end
            end
            stq_pkg::S_FIND: begin
                if (!r_ph) begin
                    if (r_pos == r_occ) begin
                        // id not present
                        if (r_op == stq_pkg::OP_ADD) begin
                            if (r_occ == CW'(stq_pkg::ENTRIES)) begin
                                n_st = stq_pkg::ST_FULL;
                                n_state = stq_pkg::S_OUT;
                            end else begin
                                n_pos = r_occ;
                                n_state = stq_pkg::S_INSERT;
                            end
                        end else begin
                            n_st = stq_pkg::ST_UNKNOWN;
                            n_state = stq_pkg::S_OUT;
                        end
                    end else begin
                        mem_re = 1'b1; mem_ra = r_pos[IW-1:0]; n_ph = 1'b1;
                    end
                end else begin
                    n_ph = 1'b0;
                    if (r_rd[47:32] == r_id) begin
                        if (r_op == stq_pkg::OP_ADD) begin
                            n_st = stq_pkg::ST_PRESENT;
                            n_state = stq_pkg::S_OUT;
                        end else begin
                            n_state = stq_pkg::S_REMOVE;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            stq_pkg::S_REMOVE, stq_pkg::S_POP: begin
                // move entry pos+1 to pos until the top is reached
                if (!r_ph) begin
                    if (r_pos + 1'b1 >= r_occ) begin
                        n_occ = r_occ - 1'b1;
                        if (r_state == stq_pkg::S_POP) begin
                            n_state = stq_pkg::S_TICK;
                        end else if (r_op == stq_pkg::OP_ADJUST) begin
                            n_pos = r_occ - 1'b1;
                            n_state = stq_pkg::S_INSERT;
                        end else begin
                            n_state = stq_pkg::S_OUT;
                        end
                    end else begin
                        mem_re = 1'b1; mem_ra = IW'(r_pos + 1'b1); n_ph = 1'b1;
                    end
                end else begin
                    mem_we = 1'b1; mem_wa = r_pos[IW-1:0]; mem_wd = r_rd;
                    n_pos = r_pos + 1'b1; n_ph = 1'b0;
                end
            end
            stq_pkg::S_INSERT: begin
                // r_pos is the hole; look below it
                if (!r_ph) begin
                    if (r_pos == '0) begin
                        mem_we = 1'b1; mem_wa = '0; mem_wd = {r_id, r_exp};
                        n_occ = r_occ + 1'b1;
                        n_state = stq_pkg::S_OUT;
                    end else begin
                        mem_re = 1'b1; mem_ra = IW'(r_pos - 1'b1); n_ph = 1'b1;
                    end
                end else begin
                    n_ph = 1'b0;
                    mem_we = 1'b1; mem_wa = r_pos[IW-1:0];
                    if (r_rd[31:0] <= r_exp) begin
                        mem_wd = {r_id, r_exp};
                        n_occ = r_occ + 1'b1;
                        n_state = stq_pkg::S_OUT;
                    end else begin
                        mem_wd = r_rd;
                        n_pos = r_pos - 1'b1;
                    end
                end
            end
            stq_pkg::S_TICK: begin
                if (!r_ph) begin
                    if (r_occ == '0 || r_npop == stq_pkg::POP_W'(stq_pkg::MAX_POP)) begin
                        n_state = stq_pkg::S_OUT; n_tick_out = 1'b0;
                        n_ov = (r_npop != '0);
                        n_st = stq_pkg::ST_OK; n_olast = 1'b1;
                        if (r_npop == '0) n_oid = '0;
                    end else begin
                        mem_re = 1'b1; mem_ra = '0; n_ph = 1'b1;
                    end
                end else begin
                    n_ph = 1'b0;
                    n_state = stq_pkg::S_OUT;
                    if (r_rd[31:0] <= r_now) begin
                        // Hold the popped id until we know whether more follow.
                        if (r_npop != '0) begin
                            n_olast = 1'b0; n_ov = 1'b1; n_tick_out = 1'b1;
                        end else begin
                            n_state = stq_pkg::S_POP; n_pos = '0;
                        end
                        n_id = r_rd[47:32];
                        if (r_npop == '0) n_oid = r_rd[47:32];
                        n_npop = r_npop + 1'b1;
                    end else begin
                        n_ov = (r_npop != '0); n_olast = 1'b1; n_tick_out = 1'b0;
                    end
                end
            end
            stq_pkg::S_OUT: begin
                if (m_axis_tready) begin
                    if (r_tick_out) begin
                        // previous id sent; the newly found one becomes pending
                        n_oid = r_id; n_pos = '0;
                        n_tick_out = 1'b0;
                        n_state = stq_pkg::S_POP;
                    end else begin
                        n_state = stq_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = stq_pkg::S_IDLE;
        endcase
    end

    assign m_axis_tvalid = (r_state == stq_pkg::S_OUT);
    assign m_axis_tdata  = {5'd0, r_ov ? r_oid : 16'd0, r_ov, r_st};
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(stq_pkg::ENTRIES)) else $error("occupancy above capacity");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("input taken while output pending");
    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == stq_pkg::ST_FULL) |-> $stable(r_occ))
        else $error("full status yet queue changed");
`endif
endmodule
